### hw/rtl/assert_macros.svh
// assertion macros used by the rtl files
// depends on nothing; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while in reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/tgks_pkg.sv
// types and codes for the trie guided node key search
// depends on nothing
package tgks_pkg;

	typedef enum logic [1:0] {
		OP_LOAD_NODE  = 2'd0,
		OP_LOAD_RANGE = 2'd1,
		OP_LOAD_SLOT  = 2'd2,
		OP_LOOKUP     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_SLOT_COUNT = 2'd0,
		CFG_PAGE_INNER = 2'd1,
		CFG_UPPER_PTR  = 2'd2,
		CFG_UNUSED     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic        leaf;
		logic [3:0]  span;
		logic [63:0] body;
	} trie_node_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_EDGE_RD,
		ST_EDGE_EV,
		ST_RNG_HI_RD,
		ST_RNG_HI_EV,
		ST_RNG_LO_RD,
		ST_RNG_LO_EV,
		ST_CLIP,
		ST_SRCH,
		ST_SRCH_EV,
		ST_FIN_RD,
		ST_FIN_EV
	} state_t;

endpackage

### hw/rtl/tgks_ram.sv
// generic single write, single read ram with registered read data
// depends on nothing
module tgks_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### hw/rtl/trie_guided_node_key_search.sv
// Key search in one B-tree page guided by an embedded trie. Load beats fill the
// trie, range and slot memories. A lookup beat walks the trie node by node
// (memory read, then evaluate), reads two or more range bounds, clips the range,
// runs a binary search in which each probe takes the midpoint with a slot key
// read and then compares, and ends with the range end check, the final slot read
// and the result. One item is in flight at a time; the result waits in an output
// register while the next load beats are taken.
// depends on tgks_pkg, tgks_ram and assert_macros.svh
`include "assert_macros.svh"

module trie_guided_node_key_search import tgks_pkg::*; #(
	parameter int TRIE_NODES  = 256,
	parameter int SLOT_DEPTH  = 4096,
	parameter int RANGE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [11:0] entry_index,
	input  logic [63:0] search_key,
	input  logic [63:0] data_word,
	input  logic        node_leaf,
	input  logic [3:0]  node_span,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [12:0] slot_position,
	output logic [63:0] result_word,
	output logic        took_upper
);
	localparam int TW = $clog2(TRIE_NODES);
	localparam int RW = $clog2(RANGE_DEPTH);
	localparam int SW = $clog2(SLOT_DEPTH);

	state_t state_q, state_d;

	logic [12:0] slot_count_q;
	logic        page_inner_q;
	logic [63:0] upper_ptr_q;

	logic [63:0]   key_q;
	logic [TW-1:0] cur_q;
	logic [3:0]    pos_q;
	logic          side_q;
	logic [7:0]    r_q, idx_q;
	logic [12:0]   hi_q, lo_q, b_q, e_q, mid_q, spos_q;
	logic          out_valid_q;

	// memory ports
	logic          trie_we, trie_re, rng_we, rng_re, slot_we, slot_re;
	logic [TW-1:0] trie_raddr;
	logic [RW-1:0] rng_raddr;
	logic [SW-1:0] slot_raddr;
	trie_node_t    node, wnode;
	logic [12:0]   rng_rdata;
	logic [63:0]   skey_rdata, sval_rdata;

	logic accept;
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign wnode   = '{leaf: node_leaf, span: node_span, body: data_word};
	assign trie_we = accept && (op == OP_LOAD_NODE) && (13'(entry_index) < 13'(TRIE_NODES));
	assign rng_we  = accept && (op == OP_LOAD_RANGE) && (13'(entry_index) < 13'(RANGE_DEPTH));
	assign slot_we = accept && (op == OP_LOAD_SLOT) && (13'(entry_index) < 13'(SLOT_DEPTH));

	tgks_ram #(.W($bits(trie_node_t)), .D(TRIE_NODES)) u_trie (
		.clk(clk), .we(trie_we), .waddr(entry_index[TW-1:0]), .wdata(wnode),
		.re(trie_re), .raddr(trie_raddr), .rdata(node)
	);
	tgks_ram #(.W(13), .D(RANGE_DEPTH)) u_range (
		.clk(clk), .we(rng_we), .waddr(entry_index[RW-1:0]), .wdata(data_word[12:0]),
		.re(rng_re), .raddr(rng_raddr), .rdata(rng_rdata)
	);
	tgks_ram #(.W(64), .D(SLOT_DEPTH)) u_slot_key (
		.clk(clk), .we(slot_we), .waddr(entry_index[SW-1:0]), .wdata(search_key),
		.re(slot_re), .raddr(slot_raddr), .rdata(skey_rdata)
	);
	tgks_ram #(.W(64), .D(SLOT_DEPTH)) u_slot_val (
		.clk(clk), .we(slot_we), .waddr(entry_index[SW-1:0]), .wdata(data_word),
		.re(slot_re), .raddr(slot_raddr), .rdata(sval_rdata)
	);

	// node evaluation
	logic [12:0] n_eff;
	logic [7:0]  kb0, dec_child, edge_child, step_child;
	logic        child_ok, cur_last, span_diff, span_gt;
	logic [3:0]  span_n, pos_next;
	logic [4:0]  pos_sum, p;
	logic [7:0]  kb, sb;
	logic [12:0] rng_val, lo_c, hi_c, e_c;
	logic [13:0] hi_p1;
	logic        out_free;

	assign n_eff = (slot_count_q > 13'(SLOT_DEPTH)) ? 13'(SLOT_DEPTH) : slot_count_q;
	assign kb0   = (pos_q < 4'd8) ? 8'(key_q >> (6'd56 - {pos_q[2:0], 3'b000})) : 8'd0;

	always_comb begin
		if (kb0 <= node.body[7:0]) begin
			dec_child = node.body[39:32];
		end else if (kb0 <= node.body[15:8]) begin
			dec_child = node.body[47:40];
		end else if (kb0 <= node.body[23:16]) begin
			dec_child = node.body[55:48];
		end else begin
			dec_child = node.body[63:56];
		end
	end

	assign edge_child = side_q ? node.body[63:56] : node.body[39:32];
	assign step_child = (state_q == ST_EDGE_EV) ? edge_child : dec_child;
	assign child_ok   = (9'(step_child) > 9'(cur_q)) && (9'(step_child) < 9'(TRIE_NODES));
	assign cur_last   = (9'(cur_q) + 9'd1) >= 9'(TRIE_NODES);
	assign span_n     = (node.span > 4'd8) ? 4'd8 : node.span;
	assign pos_sum    = 5'(pos_q) + 5'(span_n);
	assign pos_next   = (pos_sum > 5'd8) ? 4'd8 : pos_sum[3:0];

	// first differing byte wins: scan from the top down so the lowest index is last
	always_comb begin
		span_diff = 1'b0;
		span_gt   = 1'b0;
		p         = '0;
		kb        = '0;
		sb        = '0;
		for (int i = 7; i >= 0; i--) begin
			p  = 5'(pos_q) + 5'(i);
			kb = (p < 5'd8) ? 8'(key_q >> (6'd56 - {p[2:0], 3'b000})) : 8'd0;
			sb = node.body[8*i +: 8];
			if ((4'(i) < span_n) && (kb != sb)) begin
				span_diff = 1'b1;
				span_gt   = kb > sb;
			end
		end
	end

	assign rng_val  = (9'(idx_q) < 9'(RANGE_DEPTH)) ? rng_rdata : 13'd0;
	assign lo_c     = (lo_q > n_eff) ? n_eff : lo_q;
	assign hi_c     = (hi_q > n_eff) ? n_eff : hi_q;
	assign hi_p1    = 14'(hi_c) + 14'd1;
	assign e_c      = page_inner_q ? ((hi_p1 > 14'(n_eff)) ? n_eff : hi_p1[12:0]) : hi_c;
	assign out_free = !out_valid_q || out_ready;

	// in SRCH the probe address is the fresh midpoint
	logic [12:0] mid_c;
	assign mid_c = b_q + ((e_q - b_q) >> 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (accept && (op == OP_LOOKUP)) state_d = ST_WALK_RD;
			ST_WALK_RD:   state_d = ST_WALK_EV;
			ST_WALK_EV: begin
				if (node.span == 4'd0) begin
					state_d = (!node.leaf && child_ok) ? ST_WALK_RD : ST_RNG_HI_RD;
				end else if (span_diff) begin
					state_d = ST_EDGE_EV;
				end else begin
					state_d = cur_last ? ST_RNG_HI_RD : ST_WALK_RD;
				end
			end
			ST_EDGE_RD:   state_d = ST_EDGE_EV;
			ST_EDGE_EV: begin
				if (node.span != 4'd0) begin
					state_d = cur_last ? ST_RNG_HI_RD : ST_EDGE_RD;
				end else begin
					state_d = (!node.leaf && child_ok) ? ST_EDGE_RD : ST_RNG_HI_RD;
				end
			end
			ST_RNG_HI_RD: state_d = ST_RNG_HI_EV;
			ST_RNG_HI_EV: state_d = ST_RNG_LO_RD;
			ST_RNG_LO_RD: state_d = ST_RNG_LO_EV;
			ST_RNG_LO_EV: state_d = ((rng_val == hi_q) && (idx_q != 8'd0)) ? ST_RNG_LO_RD : ST_CLIP;
			ST_CLIP:      state_d = ST_SRCH;
			ST_SRCH:      state_d = (b_q < e_q) ? ST_SRCH_EV : ST_FIN_RD;
			ST_SRCH_EV:   state_d = (key_q == skey_rdata) ? ST_FIN_RD : ST_SRCH;
			ST_FIN_RD:    state_d = ST_FIN_EV;
			ST_FIN_EV:    if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// memory read controls
	always_comb begin
		trie_re    = 1'b0;
		rng_re     = 1'b0;
		slot_re    = 1'b0;
		trie_raddr = cur_q;
		rng_raddr  = idx_q[RW-1:0];
		slot_raddr = mid_q[SW-1:0];
		unique case (state_q)
			ST_WALK_RD, ST_EDGE_RD: trie_re = 1'b1;
			ST_RNG_HI_RD: begin
				rng_re    = 1'b1;
				rng_raddr = r_q[RW-1:0];
			end
			ST_RNG_LO_RD: rng_re = 1'b1;
			ST_SRCH: begin
				slot_re    = (b_q < e_q);
				slot_raddr = mid_c[SW-1:0];
			end
			ST_FIN_RD: begin
				slot_re    = 1'b1;
				slot_raddr = spos_q[SW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_count_q <= '0;
			page_inner_q <= 1'b0;
			upper_ptr_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_SLOT_COUNT: slot_count_q <= cfg_data[12:0];
					CFG_PAGE_INNER: page_inner_q <= cfg_data[0];
					CFG_UPPER_PTR:  upper_ptr_q  <= cfg_data;
					default:        ;
				endcase
			end
			if (state_q == ST_FIN_EV && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				key_q <= search_key;
				cur_q <= '0;
				pos_q <= '0;
			end
			ST_WALK_EV: begin
				if (node.span == 4'd0) begin
					if (node.leaf) begin
						r_q <= (dec_child == 8'd0) ? 8'd1 : dec_child;
					end else if (child_ok) begin
						cur_q <= step_child[TW-1:0];
					end else begin
						r_q <= 8'd1;
					end
				end else if (span_diff) begin
					side_q <= span_gt;
				end else if (cur_last) begin
					r_q <= 8'd1;
				end else begin
					cur_q <= cur_q + TW'(1);
					pos_q <= pos_next;
				end
			end
			ST_EDGE_EV: begin
				if (node.span != 4'd0) begin
					if (cur_last) begin
						r_q <= 8'd1;
					end else begin
						cur_q <= cur_q + TW'(1);
					end
				end else if (node.leaf) begin
					r_q <= (edge_child == 8'd0) ? 8'd1 : edge_child;
				end else if (child_ok) begin
					cur_q <= step_child[TW-1:0];
				end else begin
					r_q <= 8'd1;
				end
			end
			ST_RNG_HI_EV: begin
				hi_q  <= (9'(r_q) < 9'(RANGE_DEPTH)) ? rng_rdata : 13'd0;
				idx_q <= r_q - 8'd1;
			end
			ST_RNG_LO_EV: begin
				lo_q <= rng_val;
				if ((rng_val == hi_q) && (idx_q != 8'd0)) begin
					idx_q <= idx_q - 8'd1;
				end
			end
			ST_CLIP: begin
				b_q <= lo_c;
				e_q <= e_c;
			end
			ST_SRCH: begin
				mid_q  <= mid_c;
				spos_q <= b_q;
			end
			ST_SRCH_EV: begin
				if (key_q < skey_rdata) begin
					e_q <= mid_q;
				end else if (key_q > skey_rdata) begin
					b_q <= mid_q + 13'd1;
				end else begin
					spos_q <= mid_q;
				end
			end
			ST_FIN_EV: begin
				if (out_free) begin
					slot_position <= spos_q;
					if (page_inner_q) begin
						found       <= 1'b1;
						took_upper  <= spos_q >= n_eff;
						result_word <= (spos_q >= n_eff) ? upper_ptr_q : sval_rdata;
					end else begin
						took_upper  <= 1'b0;
						found       <= (spos_q < n_eff) && (skey_rdata == key_q);
						result_word <= ((spos_q < n_eff) && (skey_rdata == key_q)) ?
							sval_rdata : 64'd0;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	`ASSERT_CLK(a_out_from_fin, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_FIN_EV), "result raised outside final state")
	`ASSERT_CLK(a_probe_in_range, clk, arst_n, (state_q == ST_SRCH_EV) |-> (mid_q < e_q), "probe beyond search range")
	`ASSERT_CLK(a_walk_advances, clk, arst_n, (state_q == ST_WALK_RD && $past(state_q == ST_WALK_EV)) |-> (cur_q > $past(cur_q)), "trie walk did not advance")
endmodule

### dv/trie_guided_node_key_search_tb.sv
// self-checking testbench for trie_guided_node_key_search: loads page stores, runs lookups
// predicts every lookup result in-line and compares beat by beat; depends on tgks_pkg
module trie_guided_node_key_search_tb;
	import tgks_pkg::*;

	localparam int LIMIT = 400000;

	typedef struct {
		op_t         kind;
		logic [11:0] idx;
		logic [63:0] key;
		logic [63:0] word;
		logic        leaf;
		logic [3:0]  span;
	} beat_t;

	typedef struct packed {
		logic        found;
		logic [12:0] pos;
		logic [63:0] word;
		logic        took_upper;
	} lookup_res_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = '0;
	logic [11:0] entry_index = '0;
	logic [63:0] search_key = '0;
	logic [63:0] data_word = '0;
	logic        node_leaf = 1'b0;
	logic [3:0]  node_span = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [12:0] slot_position;
	logic [63:0] result_word;
	logic        took_upper;

	trie_guided_node_key_search DUT (.*);

	// page image as the block should hold it, with written marks
	trie_node_t  node_img [256];
	bit          node_ok [256];
	logic [12:0] bound_img [256];
	bit          bound_ok [256];
	logic [63:0] slot_key_img [4096];
	logic [63:0] slot_val_img [4096];
	bit          slot_ok [4096];
	int unsigned slot_count_reg;
	bit          inner_reg;
	logic [63:0] upper_reg;
	bit          touches_unwritten;

	lookup_res_t pending_lookups [$];
	int          mismatches, lookups_seen, hits_seen, upper_seen;
	int          hold_cycles, cycles;
	bit          steady;
	logic [63:0] page_keys [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic trie_node_t node_rd(int unsigned i);
		if (!node_ok[i]) touches_unwritten = 1;
		return node_img[i];
	endfunction

	function automatic int unsigned bound_rd(int unsigned i);
		if (i >= 256) return 0;
		if (!bound_ok[i]) touches_unwritten = 1;
		return bound_img[i];
	endfunction

	function automatic logic [63:0] slot_key_rd(int unsigned i);
		if (!slot_ok[i]) touches_unwritten = 1;
		return slot_key_img[i];
	endfunction

	function automatic logic [63:0] slot_val_rd(int unsigned i);
		if (!slot_ok[i]) touches_unwritten = 1;
		return slot_val_img[i];
	endfunction

	function automatic int unsigned key_byte(logic [63:0] k, int unsigned p);
		if (p >= 8) return 0;
		return k[63-8*p -: 8];
	endfunction

	// outermost edge below a node: side 0 leftmost, 3 rightmost
	function automatic int unsigned outer_range(int unsigned cur, int unsigned side);
		trie_node_t nd;
		int unsigned child;
		forever begin
			nd = node_rd(cur);
			while (nd.span != 0) begin
				cur++;
				if (cur >= 256) return 1;
				nd = node_rd(cur);
			end
			child = nd.body[8*(4+side) +: 8];
			if (nd.leaf) return child;
			if (child <= cur) return 1;
			cur = child;
		end
	endfunction

	function automatic int unsigned trie_range(logic [63:0] k);
		int unsigned cur, pos, child, b, n, kb, sb;
		trie_node_t nd;
		cur = 0;
		pos = 0;
		forever begin
			nd = node_rd(cur);
			if (nd.span == 0) begin
				b = key_byte(k, pos);
				child = nd.body[63:56];
				for (int i = 0; i < 3; i++) begin
					if (b <= nd.body[8*i +: 8]) begin
						child = nd.body[8*(4+i) +: 8];
						break;
					end
				end
				if (nd.leaf) return child;
				if (child <= cur) return 1;
				cur = child;
			end else begin
				n = nd.span > 8 ? 8 : nd.span;
				for (int i = 0; i < n; i++) begin
					kb = key_byte(k, pos + i);
					sb = nd.body[8*i +: 8];
					if (kb != sb) return kb > sb ? outer_range(cur, 3) : outer_range(cur, 0);
				end
				pos = pos + n > 8 ? 8 : pos + n;
				if (cur + 1 >= 256) return 1;
				cur++;
			end
		end
	endfunction

	function automatic int unsigned slot_search(logic [63:0] k, int unsigned b, int unsigned e);
		int unsigned mid;
		logic [63:0] sk;
		while (b < e) begin
			mid = b + (e - b) / 2;
			sk = slot_key_rd(mid);
			if (k < sk) e = mid;
			else if (k > sk) b = mid + 1;
			else return mid;
		end
		return b;
	endfunction

	function automatic lookup_res_t predict_lookup(logic [63:0] k);
		int unsigned n, r, lo, hi, pos, e;
		int j;
		lookup_res_t res;
		n = slot_count_reg > 4096 ? 4096 : slot_count_reg;
		r = trie_range(k);
		if (r < 1) r = 1;
		lo = bound_rd(r - 1);
		hi = bound_rd(r);
		j = int'(r) - 2;
		// equal bounds: walk the lower bound further left
		while (lo == hi && j >= 0) begin
			lo = bound_rd(j);
			j--;
		end
		if (lo > n) lo = n;
		if (hi > n) hi = n;
		res = '0;
		if (inner_reg) begin
			e = hi + 1 > n ? n : hi + 1;
			pos = slot_search(k, lo, e);
			res.found = 1'b1;
			res.pos = pos[12:0];
			if (pos >= n) begin
				res.word = upper_reg;
				res.took_upper = 1'b1;
			end else res.word = slot_val_rd(pos);
		end else begin
			pos = slot_search(k, lo, hi);
			res.pos = pos[12:0];
			if (pos < n && slot_key_rd(pos) == k) begin
				res.found = 1'b1;
				res.word = slot_val_rd(pos);
			end
		end
		return res;
	endfunction

	function automatic void absorb_beat(beat_t b);
		case (b.kind)
			OP_LOAD_NODE: if (b.idx < 256) begin
				node_img[b.idx] = '{leaf: b.leaf, span: b.span, body: b.word};
				node_ok[b.idx] = 1;
			end
			OP_LOAD_RANGE: if (b.idx < 256) begin
				bound_img[b.idx] = b.word[12:0];
				bound_ok[b.idx] = 1;
			end
			OP_LOAD_SLOT: begin
				slot_key_img[b.idx] = b.key;
				slot_val_img[b.idx] = b.word;
				slot_ok[b.idx] = 1;
			end
			OP_LOOKUP: pending_lookups = {pending_lookups, predict_lookup(b.key)};
		endcase
	endfunction

	task automatic send_beat(beat_t b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= b.kind;
		entry_index <= b.idx;
		search_key <= b.key;
		data_word <= b.word;
		node_leaf <= b.leaf;
		node_span <= b.span;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		absorb_beat(b);
	endtask

	task automatic load_node(int idx, bit leaf, int span, logic [63:0] body);
		send_beat('{OP_LOAD_NODE, 12'(idx), {$urandom, $urandom}, body, leaf, 4'(span)});
	endtask

	task automatic load_bound(int idx, logic [63:0] w);
		send_beat('{OP_LOAD_RANGE, 12'(idx), {$urandom, $urandom}, w, 1'($urandom), 4'($urandom)});
	endtask

	task automatic load_slot(int idx, logic [63:0] k, logic [63:0] w);
		send_beat('{OP_LOAD_SLOT, 12'(idx), k, w, 1'($urandom), 4'($urandom)});
	endtask

	// only sends the lookup when it stays inside written entries
	task automatic lookup(logic [63:0] k, output bit sent);
		lookup_res_t unused;
		touches_unwritten = 0;
		unused = predict_lookup(k);
		sent = !touches_unwritten;
		if (sent)
			send_beat('{OP_LOOKUP, 12'($urandom), k, {$urandom, $urandom}, 1'($urandom),
				4'($urandom)});
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_lookups.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// leaves the write enable high; the caller drops it after the last write
	task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			CFG_SLOT_COUNT: slot_count_reg = v[12:0];
			CFG_PAGE_INNER: inner_reg = v[0];
			CFG_UPPER_PTR:  upper_reg = v;
			default: ;
		endcase
	endtask

	task automatic configure(logic [63:0] cnt, bit inner, logic [63:0] upper);
		settle();
		write_reg(CFG_SLOT_COUNT, cnt);
		write_reg(CFG_PAGE_INNER, {$urandom, $urandom} & ~64'h1 | 64'(inner));
		write_reg(CFG_UPPER_PTR, upper);
		cfg_we <= 1'b0;
	endtask

	// hand-built page: spans, long span, bad links, equal and inverted bounds
	task automatic test_fixed_page();
		int bounds [12] = '{0, 2, 4, 5, 7, 9, 11, 12, 12, 14, 20, 3};
		load_node(0, 0, 0, 64'h06_05_03_01_00_BF_7F_3F);
		load_node(1, 1, 1, 64'h20);
		load_node(2, 1, 0, 64'h03_00_02_01_00_F0_80_10);
		load_node(3, 0, 9, 64'h05_00_00_00_00_00_20_50);
		load_node(4, 1, 0, 64'h07_06_05_04_00_09_05_00);
		load_node(5, 0, 0, 64'h07_05_00_01_00_B0_A0_90);
		load_node(6, 1, 0, 64'hFF_09_08_08_00_F8_E0_D0);
		load_node(7, 1, 0, 64'h03_0C_0B_0A_00_FF_10_00);
		foreach (bounds[i])
			load_bound(i, 64'(bounds[i]));
		load_bound(12, 64'hFFFF_FFFF_FFFF_FFFF);
		load_bound(254, 1);
		load_bound(255, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < 15; i++)
			load_slot(i, {8'(i * 16), 8'h20, 48'(i)}, ~{8'(i * 16), 56'(i)});
		load_slot(15, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	task automatic test_fixed_lookups();
		logic [63:0] probes [16] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h2000_0000_0000_0000,
			64'h2050_0000_0000_0000, 64'h20A0_0000_0000_0000, 64'h20F5_0000_0000_0000,
			64'h1000_0000_0000_0000, 64'h3000_0000_0000_0000, 64'h5020_0000_0000_0005,
			64'h5020_0000_0000_0006, 64'h4800_0000_0000_0000, 64'h8800_0000_0000_0000,
			64'h9800_0000_0000_0000, 64'hB800_0000_0000_0000, 64'hC000_0000_0000_0000,
			64'h3020_0000_0000_0003};
		bit sent;
		foreach (probes[i]) lookup(probes[i], sent);
	endtask

	// loads at indexes beyond the trie and range depths are dropped by the block
	task automatic test_ignored_loads();
		bit sent;
		load_node(256 + $urandom_range(0, 3839), 1, 15, 64'hFFFF_FFFF_FFFF_FFFF);
		load_bound(4095, 64'h0);
		load_node(4095, 0, 8, 64'h0);
		load_bound(256, 64'hFFFF_FFFF_FFFF_FFFF);
		lookup(64'h2050_0000_0000_0000, sent);
		lookup(64'h5020_0000_0000_0005, sent);
	endtask

	task automatic build_random_page(int nslots);
		logic [63:0] k, body;
		int nodes, kind, last;
		k = {$urandom, $urandom} >> $urandom_range(8, 40);
		page_keys.delete();
		for (int i = 0; i < nslots; i++) begin
			page_keys = {page_keys, k};
			load_slot(i, k, {$urandom, $urandom});
			k += {$urandom, $urandom} >> 6;
		end
		last = 0;
		for (int i = 0; i < 16; i++) begin
			if (i > 0 && $urandom_range(0, 9) == 0) last = $urandom_range(0, nslots);
			else if ($urandom_range(0, 3) != 0) last = $urandom_range(last, nslots);
			load_bound(i, $urandom_range(0, 19) == 0 ? {$urandom, $urandom} : 64'(last));
		end
		nodes = $urandom_range(4, 10);
		for (int i = 0; i < nodes; i++) begin
			kind = (i == nodes - 1) ? 0 : $urandom_range(0, 2);
			body = {$urandom, $urandom};
			if (kind == 2) begin
				// span copied from a slot key so that some lookups match it
				k = page_keys[$urandom_range(0, nslots - 1)];
				for (int b = 0; b < 8; b++)
					body[8*b +: 8] = 8'(key_byte(k, $urandom_range(0, 1) + b));
				load_node(i, 1'($urandom), $urandom_range(1, 15), body);
			end else if (kind == 1) begin
				for (int c = 4; c < 8; c++)
					body[8*c +: 8] = $urandom_range(0, 7) == 0 ? 8'($urandom_range(0, i)) :
						8'($urandom_range(i + 1, nodes - 1));
				load_node(i, 0, 0, body);
			end else begin
				for (int c = 4; c < 8; c++) body[8*c +: 8] = 8'($urandom_range(0, 15));
				load_node(i, 1, 0, body);
			end
		end
	endtask

	task automatic test_random_page(int nslots, int nlookups);
		logic [63:0] k;
		bit sent;
		build_random_page(nslots);
		for (int n = 0; n < nlookups; n++) begin
			for (int tries = 0; tries < 20; tries++) begin
				k = page_keys[$urandom_range(0, nslots - 1)];
				case ($urandom_range(0, 4))
					0: k = k + 1;
					1: k = k - 1;
					2: k = {$urandom, $urandom};
					default: ;
				endcase
				lookup(k, sent);
				if (sent) break;
			end
		end
	endtask

	// receiver stalls long enough for the block to hold a result and refuse input
	task automatic test_backpressure();
		bit sent;
		hold_cycles = 300;
		steady = 1;
		for (int i = 0; i < 12; i++) lookup(page_keys[$urandom_range(0, page_keys.size() - 1)],
			sent);
		steady = 0;
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) hold_cycles--;
		end
	end

	// result side: check each beat against the oldest prediction, then stall at random unless steady
	initial begin
		lookup_res_t want;
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				lookups_seen++;
				if (pending_lookups.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result beat pos=%0d", slot_position);
				end else begin
					want = pending_lookups.pop_front();
					if (found !== want.found || slot_position !== want.pos ||
							result_word !== want.word || took_upper !== want.took_upper) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp found=%b pos=%0d word=%h upper=%b, got %b %0d %h %b",
								want.found, want.pos, want.word, want.took_upper,
								found, slot_position, result_word, took_upper);
					end
					hits_seen += want.found && !inner_reg;
					upper_seen += want.took_upper;
				end
				stall = steady ? 0 : $urandom_range(0, 4);
			end else if (stall > 0) stall--;
			out_ready <= (stall == 0 && hold_cycles == 0);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("trie_guided_node_key_search_tb NOT OK");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		configure(16, 0, 64'hFFFF_FFFF_FFFF_FFFF);
		test_fixed_page();
		test_fixed_lookups();
		configure(16, 1, 64'hFFFF_FFFF_FFFF_FFFF);
		test_fixed_lookups();
		configure(0, 1, 64'h0);
		test_fixed_lookups();
		configure(64'hFFFF_FFFF_FFFF_FFFF, 0, {$urandom, $urandom});
		test_fixed_lookups();
		test_ignored_loads();
		for (int p = 0; p < 6; p++) begin
			configure($urandom_range(0, 3) == 0 ? {$urandom, $urandom} : $urandom_range(8, 40),
				p[0], {$urandom, $urandom});
			steady = (p == 2);
			test_random_page($urandom_range(8, 40), 15);
			steady = 0;
		end
		test_backpressure();
		settle();
		$display("lookups checked: %0d, leaf hits: %0d, upper pointer returns: %0d",
			lookups_seen, hits_seen, upper_seen);
		$display("covered fixed trie corner walks, six random pages, ignored loads, long stall");
		if (mismatches == 0 && pending_lookups.size() == 0)
			$display("trie_guided_node_key_search_tb OK");
		else
			$display("trie_guided_node_key_search_tb NOT OK");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tgks_pkg.sv
hw/rtl/tgks_ram.sv
hw/rtl/trie_guided_node_key_search.sv
dv/trie_guided_node_key_search_tb.sv
